FILE: design/apm_pkg.sv
// ----------------------------------------------------------------------------
// apm_pkg
// Shared types and constants for the anemometer pulse rate meter.
// ----------------------------------------------------------------------------
package apm_pkg;

  localparam int unsigned SINCE_W    = 16;
  localparam int unsigned WIN_W      = 12;
  localparam int unsigned TALLY_W    = 8;
  localparam int unsigned SPH_W      = 12;
  localparam int unsigned FS_W       = 16;
  localparam int unsigned SPEED_W    = 20;
  localparam int unsigned PCT_W      = 7;
  localparam int unsigned NUM_W      = 27;   // speed * 100
  localparam int unsigned LIM_W      = 23;   // full scale * 100
  localparam int unsigned DIV_STEPS  = 7;    // quotient bits below the clamp
  localparam int unsigned STEP_W     = 3;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [PCT_W-1:0]   PCT_FULL  = 7'd100;
  localparam logic [TALLY_W-1:0] TALLY_MAX = '1;

  typedef enum logic [1:0] {
    REG_MIN_INTERVAL = 2'd0,
    REG_WINDOW       = 2'd1,
    REG_SPEED_PER_HZ = 2'd2,
    REG_FULL_SCALE   = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [SINCE_W-1:0] min_interval_ms;
    logic [WIN_W-1:0]   window_ms;
    logic [SPH_W-1:0]   speed_per_hz_mm;
    logic [FS_W-1:0]    full_scale_mm_s;
  } apm_cfg_t;

  // window-end record from the front part to the back part
  typedef struct packed {
    logic               valid;
    logic [TALLY_W-1:0] pulses;
  } apm_rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } apm_qstat_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_SCALE,
    BK_CHECK,
    BK_DIV
  } back_state_t;

endpackage

FILE: design/anemometer_pulse_rate_meter_core.sv
// ----------------------------------------------------------------------------
// anemometer_pulse_rate_meter_core
// Counts filtered sensor edges per window of ticks and reports speed/percent.
// ----------------------------------------------------------------------------
//  channel  | ports                         | transfer when
//  ---------+-------------------------------+-------------------------------
//  ticks    | in_push, in_full, in_*        | in_push && !in_full
//  results  | out_empty, out_pop, out_*     | out_pop && !out_empty
//  config   | cfg_psel .. cfg_pready        | psel, penable, pwrite, pready
//
// One tick is taken per cycle while the record queue has room.
// In the back part a window result passes through pop, multiply, scale, clamp
// check and, unless the percent clamps or full scale is zero, a 7-step
// restoring division for the percent.
// Synchronous active-low reset restores register defaults and clears timers.
// A waiting result stalls only the back part; ticks stall once the queue fills.
module anemometer_pulse_rate_meter_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_push,
  output logic                           in_full,
  input  logic                           in_falling_edge,
  output logic                           out_empty,
  input  logic                           out_pop,
  output logic [apm_pkg::TALLY_W-1:0]    out_pulses_in_window,
  output logic [apm_pkg::SPEED_W-1:0]    out_wind_speed_mm_s,
  output logic [apm_pkg::PCT_W-1:0]      out_wind_percent,
  output logic                           out_wind_present,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [apm_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [apm_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [apm_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready
);
  import apm_pkg::*;

  apm_cfg_t           cfg_r, cfg_nxt;
  reg_idx_t           reg_idx;
  logic               cfg_wr;
  apm_rec_t           rec;
  apm_qstat_t         qstat;
  logic [TALLY_W-1:0] q_data;
  logic               q_pop;
  logic               tick_valid;

  assign cfg_pready = 1'b1;
  assign reg_idx    = reg_idx_t'(cfg_paddr[3:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign in_full    = qstat.full;
  assign tick_valid = in_push && !in_full;

  always_comb begin
    cfg_nxt    = cfg_r;
    cfg_prdata = '0;
    unique case (reg_idx)
      REG_MIN_INTERVAL: begin
        cfg_prdata = CFG_DATA_W'(cfg_r.min_interval_ms);
        if (cfg_wr) cfg_nxt.min_interval_ms = cfg_pwdata[SINCE_W-1:0];
      end
      REG_WINDOW: begin
        cfg_prdata = CFG_DATA_W'(cfg_r.window_ms);
        if (cfg_wr) cfg_nxt.window_ms = cfg_pwdata[WIN_W-1:0];
      end
      REG_SPEED_PER_HZ: begin
        cfg_prdata = CFG_DATA_W'(cfg_r.speed_per_hz_mm);
        if (cfg_wr) cfg_nxt.speed_per_hz_mm = cfg_pwdata[SPH_W-1:0];
      end
      REG_FULL_SCALE: begin
        cfg_prdata = CFG_DATA_W'(cfg_r.full_scale_mm_s);
        if (cfg_wr) cfg_nxt.full_scale_mm_s = cfg_pwdata[FS_W-1:0];
      end
      default: cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_interval_ms <= 16'd80;
      cfg_r.window_ms       <= 12'd1000;
      cfg_r.speed_per_hz_mm <= 12'd1133;
      cfg_r.full_scale_mm_s <= 16'd10000;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  apm_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .tick_valid   (tick_valid),
    .falling_edge (in_falling_edge),
    .rec          (rec)
  );

  apm_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (rec),
    .rd      (q_pop),
    .rd_data (q_data),
    .stat    (qstat)
  );

  apm_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg                  (cfg_r),
    .qstat                (qstat),
    .q_data               (q_data),
    .q_pop                (q_pop),
    .out_empty            (out_empty),
    .out_pop              (out_pop),
    .out_pulses_in_window (out_pulses_in_window),
    .out_wind_speed_mm_s  (out_wind_speed_mm_s),
    .out_wind_percent     (out_wind_percent),
    .out_wind_present     (out_wind_present)
  );

endmodule

FILE: design/apm_front.sv
// ----------------------------------------------------------------------------
// apm_front
// Tick handler: interval and window timers, edge filter and pulse tally.
// ----------------------------------------------------------------------------
module apm_front (
  input  logic              clk,
  input  logic              rst_n,
  input  apm_pkg::apm_cfg_t cfg,
  input  logic              tick_valid,
  input  logic              falling_edge,
  output apm_pkg::apm_rec_t rec
);
  import apm_pkg::*;

  logic [SINCE_W-1:0] since_r, since_nxt, since_inc;
  logic [WIN_W-1:0]   win_r, win_nxt, win_inc;
  logic [TALLY_W-1:0] tally_r, tally_nxt, tally_upd;
  logic               win_end;

  always_comb begin
    since_inc = (since_r == '1) ? since_r : since_r + 1'b1;
    win_inc   = (win_r == '1) ? win_r : win_r + 1'b1;
    tally_upd = tally_r;
    since_nxt = since_inc;
    if (falling_edge) begin
      if (since_inc >= cfg.min_interval_ms && tally_r != TALLY_MAX) begin
        tally_upd = tally_r + 1'b1;
      end
      since_nxt = '0;
    end
    win_end   = (win_inc >= cfg.window_ms);
    win_nxt   = win_end ? '0 : win_inc;
    tally_nxt = win_end ? '0 : tally_upd;
    rec.valid  = tick_valid && win_end;
    rec.pulses = tally_upd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      since_r <= '0;
      win_r   <= '0;
      tally_r <= '0;
    end else if (tick_valid) begin
      since_r <= since_nxt;
      win_r   <= win_nxt;
      tally_r <= tally_nxt;
    end
  end

endmodule

FILE: design/apm_queue.sv
// ----------------------------------------------------------------------------
// apm_queue
// Short queue of window-end records between the front and back parts.
// ----------------------------------------------------------------------------
module apm_queue (
  input  logic                          clk,
  input  logic                          rst_n,
  input  apm_pkg::apm_rec_t             wr,
  input  logic                          rd,
  output logic [apm_pkg::TALLY_W-1:0]   rd_data,
  output apm_pkg::apm_qstat_t           stat
);
  import apm_pkg::*;

  logic [TALLY_W-1:0] mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QCNT_W-1:0]  cnt_r, cnt_nxt;
  logic               do_wr, do_rd;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    stat.full  = (cnt_r == QCNT_W'(QUEUE_DEPTH));
    stat.empty = (cnt_r == '0);
    do_wr   = wr.valid && !stat.full;
    do_rd   = rd && !stat.empty;
    wp_nxt  = do_wr ? ptr_inc(wp_r) : wp_r;
    rp_nxt  = do_rd ? ptr_inc(rp_r) : rp_r;
    cnt_nxt = cnt_r + QCNT_W'(do_wr) - QCNT_W'(do_rd);
    rd_data = mem_r[rp_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wr.pulses;
    end
  end

endmodule

FILE: design/apm_back.sv
// ----------------------------------------------------------------------------
// apm_back
// Speed multiply, clamped percent by restoring division, result register.
// ----------------------------------------------------------------------------
module apm_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  apm_pkg::apm_cfg_t           cfg,
  input  apm_pkg::apm_qstat_t         qstat,
  input  logic [apm_pkg::TALLY_W-1:0] q_data,
  output logic                        q_pop,
  output logic                        out_empty,
  input  logic                        out_pop,
  output logic [apm_pkg::TALLY_W-1:0] out_pulses_in_window,
  output logic [apm_pkg::SPEED_W-1:0] out_wind_speed_mm_s,
  output logic [apm_pkg::PCT_W-1:0]   out_wind_percent,
  output logic                        out_wind_present
);
  import apm_pkg::*;

  back_state_t        state_r, state_nxt;
  logic [TALLY_W-1:0] pulses_r;
  logic [SPEED_W-1:0] speed_r;
  logic [NUM_W-1:0]   rem_r, rem_nxt;
  logic [LIM_W-1:0]   lim_r;
  logic [PCT_W-1:0]   quo_r, quo_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic               ovalid_r, ovalid_nxt;
  logic [PCT_W-1:0]   opct_r;
  logic [TALLY_W-1:0] opulses_r;
  logic [SPEED_W-1:0] ospeed_r;
  logic               load;
  logic [PCT_W-1:0]   pct_new;
  logic [NUM_W-1:0]   trial;
  logic               ge;

  assign out_empty            = !ovalid_r;
  assign out_pulses_in_window = opulses_r;
  assign out_wind_speed_mm_s  = ospeed_r;
  assign out_wind_percent     = opct_r;
  assign out_wind_present     = (opct_r != '0);

  always_comb begin
    state_nxt  = state_r;
    rem_nxt    = rem_r;
    quo_nxt    = quo_r;
    step_nxt   = step_r;
    q_pop      = 1'b0;
    load       = 1'b0;
    pct_new    = '0;
    trial      = NUM_W'(cfg.full_scale_mm_s) << step_r;
    ge         = (rem_r >= trial);
    ovalid_nxt = ovalid_r && !out_pop;
    unique case (state_r)
      BK_IDLE: begin
        if (!qstat.empty && !ovalid_r) begin
          q_pop     = 1'b1;
          state_nxt = BK_MUL;
        end
      end
      BK_MUL:   state_nxt = BK_SCALE;
      BK_SCALE: begin
        rem_nxt   = NUM_W'(speed_r) * NUM_W'(100);
        state_nxt = BK_CHECK;
      end
      BK_CHECK: begin
        if (cfg.full_scale_mm_s == '0) begin
          load      = 1'b1;
          pct_new   = (speed_r != '0) ? PCT_FULL : '0;
          state_nxt = BK_IDLE;
        end else if (rem_r >= NUM_W'(lim_r)) begin
          load      = 1'b1;
          pct_new   = PCT_FULL;
          state_nxt = BK_IDLE;
        end else begin
          // quotient now fits in seven bits
          quo_nxt   = '0;
          step_nxt  = STEP_W'(DIV_STEPS - 1);
          state_nxt = BK_DIV;
        end
      end
      BK_DIV: begin
        if (ge) begin
          rem_nxt = rem_r - trial;
        end
        quo_nxt  = {quo_r[PCT_W-2:0], ge};
        step_nxt = step_r - 1'b1;
        if (step_r == '0) begin
          load      = 1'b1;
          pct_new   = quo_nxt;
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
    if (load) begin
      ovalid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= BK_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      pulses_r <= q_data;
    end
    if (state_r == BK_MUL) begin
      speed_r <= SPEED_W'(pulses_r) * SPEED_W'(cfg.speed_per_hz_mm);
    end
    if (state_r == BK_SCALE) begin
      lim_r <= LIM_W'(cfg.full_scale_mm_s) * LIM_W'(100);
    end
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    step_r <= step_nxt;
    if (load) begin
      opulses_r <= pulses_r;
      ospeed_r  <= speed_r;
      opct_r    <= pct_new;
    end
  end

endmodule

FILE: design/apm_checker.sv
// ----------------------------------------------------------------------------
// apm_checker
// Port-level checks on the result channel of the pulse rate meter.
// ----------------------------------------------------------------------------
module apm_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_empty,
  input logic                        out_pop,
  input logic [apm_pkg::TALLY_W-1:0] out_pulses_in_window,
  input logic [apm_pkg::SPEED_W-1:0] out_wind_speed_mm_s,
  input logic [apm_pkg::PCT_W-1:0]   out_wind_percent,
  input logic                        out_wind_present
);
  import apm_pkg::*;

  // nothing waits in the first cycle after reset
  a_empty_after_reset: assert property (@(posedge clk)
    !rst_n |=> out_empty)
    else $error("result shown straight after reset");

  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_wind_percent <= PCT_FULL)
    else $error("percent above full scale");

  a_airflow: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_wind_present == (out_wind_percent != '0)))
    else $error("airflow flag disagrees with percent");

  // no pulses means no speed, and no speed means no percent
  a_zero_chain: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_pulses_in_window == '0 |->
      out_wind_speed_mm_s == '0 && out_wind_percent == '0)
    else $error("speed or percent without pulses");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_wind_speed_mm_s)
      && $stable(out_wind_percent) && $stable(out_pulses_in_window))
    else $error("waiting result changed");

endmodule

bind anemometer_pulse_rate_meter_core apm_checker u_apm_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .out_empty            (out_empty),
  .out_pop              (out_pop),
  .out_pulses_in_window (out_pulses_in_window),
  .out_wind_speed_mm_s  (out_wind_speed_mm_s),
  .out_wind_percent     (out_wind_percent),
  .out_wind_present     (out_wind_present)
);

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives millisecond ticks into the anemometer pulse rate meter and checks
// each window report against an in-bench tracker of the same counters. The
// stimulus covers directed corner settings, then random phases, with the
// settings rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module testbench;
  import apm_pkg::*;

  localparam int unsigned     HALF_PERIOD        = 10;
  localparam int unsigned     SETTLE_CYCLES      = 32;
  localparam int unsigned     HOLD_OFF_CYCLES    = 400;
  localparam int unsigned     RANDOM_TICKS       = 1200;
  localparam longint unsigned RUN_LIMIT          = 20_000_000;

  typedef struct packed {
    logic [TALLY_W-1:0] pulses;
    logic [SPEED_W-1:0] speed;
    logic [PCT_W-1:0]   percent;
    logic               airflow;
  } wind_report_t;

  // Tracks timers, tally and settings; queues the report each window end gives.
  class wind_report_tracker;
    logic [SINCE_W-1:0] min_interval;
    logic [WIN_W-1:0]   window_len;
    logic [SPH_W-1:0]   speed_per_rev;
    logic [FS_W-1:0]    full_scale;
    logic [SINCE_W-1:0] since_edge;
    logic [WIN_W-1:0]   elapsed;
    logic [TALLY_W-1:0] tally;
    wind_report_t       awaited[$];
    int unsigned        failures;

    function new();
      min_interval  = 16'd80;
      window_len    = 12'd1000;
      speed_per_rev = 12'd1133;
      full_scale    = 16'd10000;
      since_edge    = '0;
      elapsed       = '0;
      tally         = '0;
      failures      = 0;
    endfunction

    function void set_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_MIN_INTERVAL: min_interval  = value[SINCE_W-1:0];
        REG_WINDOW:       window_len    = value[WIN_W-1:0];
        REG_SPEED_PER_HZ: speed_per_rev = value[SPH_W-1:0];
        REG_FULL_SCALE:   full_scale    = value[FS_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_tick(bit fell);
      wind_report_t rep;
      int unsigned  speed;
      int unsigned  pct;
      if (since_edge != '1) since_edge++;
      if (elapsed != '1) elapsed++;
      if (fell) begin
        if (since_edge >= min_interval && tally != TALLY_MAX) tally++;
        since_edge = '0;
      end
      if (elapsed >= window_len) begin
        speed = 32'(tally) * 32'(speed_per_rev);
        if (full_scale == '0) begin
          pct = (speed != 0) ? 100 : 0;
        end else begin
          pct = speed * 100 / 32'(full_scale);
          if (pct > 100) pct = 100;
        end
        rep.pulses  = tally;
        rep.speed   = speed[SPEED_W-1:0];
        rep.percent = pct[PCT_W-1:0];
        rep.airflow = (pct != 0);
        awaited.push_back(rep);
        tally   = '0;
        elapsed = '0;
      end
    endfunction

    function void complain(string msg);
      failures++;
      if (failures <= 10) $display("%s", msg);
    endfunction

    function void check_report(wind_report_t got);
      wind_report_t want;
      if (awaited.size() == 0) begin
        complain($sformatf("report with none awaited: pulses %0d speed %0d pct %0d",
                           got.pulses, got.speed, got.percent));
        return;
      end
      want = awaited.pop_front();
      if (got.pulses !== want.pulses)
        complain($sformatf("pulses_in_window: expected %0d, got %0d", want.pulses, got.pulses));
      if (got.speed !== want.speed)
        complain($sformatf("wind_speed_mm_s: expected %0d, got %0d", want.speed, got.speed));
      if (got.percent !== want.percent)
        complain($sformatf("wind_percent: expected %0d, got %0d", want.percent, got.percent));
      if (got.airflow !== want.airflow)
        complain($sformatf("wind_present: expected %0d, got %0d", want.airflow, got.airflow));
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_push;
  logic                  in_full;
  logic                  in_falling_edge;
  logic                  out_empty;
  logic                  out_pop;
  logic [TALLY_W-1:0]    out_pulses_in_window;
  logic [SPEED_W-1:0]    out_wind_speed_mm_s;
  logic [PCT_W-1:0]      out_wind_percent;
  logic                  out_wind_present;
  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  bit rx_steady     = 1'b0;
  bit hold_off_req  = 1'b0;

  wind_report_tracker wind_reports = new;

  anemometer_pulse_rate_meter_core dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_push              (in_push),
    .in_full              (in_full),
    .in_falling_edge      (in_falling_edge),
    .out_empty            (out_empty),
    .out_pop              (out_pop),
    .out_pulses_in_window (out_pulses_in_window),
    .out_wind_speed_mm_s  (out_wind_speed_mm_s),
    .out_wind_percent     (out_wind_percent),
    .out_wind_present     (out_wind_present),
    .cfg_psel             (cfg_psel),
    .cfg_penable          (cfg_penable),
    .cfg_pwrite           (cfg_pwrite),
    .cfg_paddr            (cfg_paddr),
    .cfg_pwdata           (cfg_pwdata),
    .cfg_prdata           (cfg_prdata),
    .cfg_pready           (cfg_pready)
  );

  always begin
    #HALF_PERIOD clk = 1'b1;
    #HALF_PERIOD clk = 1'b0;
  end

  // mostly back to back, some short gaps, the odd long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic write_reg(reg_idx_t idx, logic [CFG_DATA_W-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    wind_reports.set_reg(idx, value);
  endtask

  task automatic set_config(logic [15:0] min_int, logic [11:0] win,
                            logic [11:0] per_rev, logic [15:0] fs);
    write_reg(REG_MIN_INTERVAL, CFG_DATA_W'(min_int));
    write_reg(REG_WINDOW, CFG_DATA_W'(win));
    write_reg(REG_SPEED_PER_HZ, CFG_DATA_W'(per_rev));
    write_reg(REG_FULL_SCALE, CFG_DATA_W'(fs));
  endtask

  task automatic push_tick(bit fell, bit steady);
    int unsigned gap;
    in_push         <= 1'b1;
    in_falling_edge <= fell;
    do @(posedge clk); while (in_full);
    wind_reports.note_tick(fell);
    gap = steady ? 0 : pick_gap();
    if (gap != 0) begin
      in_push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drive_ticks(int unsigned count, int unsigned fall_pct, bit steady);
    for (int unsigned i = 0; i < count; i++)
      push_tick($urandom_range(1, 100) <= fall_pct, steady);
  endtask

  // sender pauses until every report is in, then lets the back part go quiet
  task automatic settle();
    in_push <= 1'b0;
    while (wind_reports.awaited.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // result side
  initial begin
    int unsigned  stall_left;
    int unsigned  hold_left;
    wind_report_t got;
    stall_left = 0;
    hold_left  = 0;
    out_pop   <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_pop && !out_empty) begin
        got.pulses  = out_pulses_in_window;
        got.speed   = out_wind_speed_mm_s;
        got.percent = out_wind_percent;
        got.airflow = out_wind_present;
        wind_reports.check_report(got);
      end
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left    = HOLD_OFF_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
        if (!rx_steady && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  initial begin
    #(RUN_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int unsigned phase;
    int unsigned random_ticks;
    int unsigned count;
    int unsigned fall_pct;
    bit          steady;
    logic [15:0] min_int;
    logic [15:0] fs;
    logic [11:0] win;
    logic [11:0] per_rev;
    logic [7:0]  pattern;

    rst_n           <= 1'b0;
    in_push         <= 1'b0;
    in_falling_edge <= 1'b0;
    cfg_psel        <= 1'b0;
    cfg_penable     <= 1'b0;
    cfg_pwrite      <= 1'b0;
    cfg_paddr       <= '0;
    cfg_pwdata      <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // defaults: edges right after reset fall inside the minimum interval
    push_tick(1'b1, 1'b1);
    push_tick(1'b0, 1'b1);
    push_tick(1'b1, 1'b1);
    settle();

    // no minimum interval, zero window, zero full scale
    set_config(16'd0, 12'd0, 12'hFFF, 16'd0);
    push_tick(1'b1, 1'b0);
    push_tick(1'b1, 1'b0);
    push_tick(1'b0, 1'b0);
    settle();

    // edges on the last tick of a window, tiny percent
    set_config(16'd2, 12'd4, 12'd1, 16'hFFFF);
    pattern = 8'b0010_1101;
    for (int i = 0; i < 8; i++) push_tick(pattern[i], 1'b0);
    settle();

    // percent clamps at full
    set_config(16'd1, 12'd3, 12'hFFF, 16'd1);
    push_tick(1'b1, 1'b0);
    push_tick(1'b1, 1'b0);
    push_tick(1'b1, 1'b0);
    push_tick(1'b0, 1'b0);
    settle();

    phase        = 0;
    random_ticks = 0;
    while (random_ticks < RANDOM_TICKS) begin
      case ($urandom_range(0, 4))
        0:       min_int = 16'd0;
        1:       min_int = 16'hFFFF;
        2:       min_int = 16'($urandom_range(1, 4));
        3:       min_int = 16'($urandom_range(2, 12));
        default: min_int = 16'($urandom);
      endcase
      case ($urandom_range(0, 5))
        0:       win = 12'd0;
        1:       win = 12'd1;
        default: win = 12'($urandom_range(2, 24));
      endcase
      case ($urandom_range(0, 3))
        0:       per_rev = 12'd0;
        1:       per_rev = 12'hFFF;
        default: per_rev = 12'($urandom);
      endcase
      case ($urandom_range(0, 4))
        0:       fs = 16'd0;
        1:       fs = 16'd1;
        2:       fs = 16'hFFFF;
        3:       fs = 16'($urandom_range(1, 8000));
        default: fs = 16'($urandom);
      endcase
      count    = $urandom_range(20, 60);
      fall_pct = $urandom_range(5, 95);
      steady   = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      if (phase == 0) begin
        // report every tick while the result side holds off: input must stall
        min_int = 16'($urandom_range(0, 3));
        win     = 12'd0;
        count   = 60;
        steady  = 1'b1;
        hold_off_req = 1'b1;
      end else if (phase == 1) begin
        // drive the tally into saturation
        min_int  = 16'd0;
        win      = 12'd300;
        per_rev  = 12'hFFF;
        count    = 320;
        fall_pct = 95;
      end
      set_config(min_int, win, per_rev, fs);
      drive_ticks(count, fall_pct, steady);
      random_ticks += count;
      settle();
      phase++;
    end

    if (wind_reports.failures == 0 && wind_reports.awaited.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

FILE: files.f
design/apm_pkg.sv
design/apm_front.sv
design/apm_queue.sv
design/apm_back.sv
design/anemometer_pulse_rate_meter_core.sv
design/apm_checker.sv
verif/testbench.sv
